### rtl/bdd_pkg.sv
`default_nettype none
package bdd_pkg;

  localparam int BLOCK_BYTES_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] HDR1 = 8'h5A;
  localparam logic [7:0] HDR2 = 8'hA5;

  localparam int DEVICE_ID_W = 16;
  localparam int XFER_SIZE_W = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int BLOCK_NUM_W = 24;

  typedef enum logic [0:0] {
    REG_DEVICE_ID     = 1'b0,
    REG_TRANSFER_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_DONE     = 3'd2,
    KIND_BAD_HDR1 = 3'd3,
    KIND_BAD_HDR2 = 3'd4,
    KIND_BAD_ID   = 3'd5,
    KIND_BAD_CSUM = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_IDLO = 3'd2,
    PH_IDHI = 3'd3,
    PH_DATA = 3'd4,
    PH_CSLO = 3'd5,
    PH_CSHI = 3'd6
  } phase_t;

  // one classified byte as it waits in the queue
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
    logic       is_hdr1;
    logic       is_hdr2;
  } bdd_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } bdd_q_status_t;

endpackage
`default_nettype wire

### rtl/bdd_front.sv
`default_nettype none
module bdd_front
  import bdd_pkg::*;
(
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // rx_byte
  input  wire logic [0:0]    s_tuser,   // restart
  input  wire bdd_q_status_t q_status,
  output logic               push,
  output bdd_item_t          item
);

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  // header compares are done here so the back end only selects
  always_comb begin
    item.rx_byte = s_tdata;
    item.restart = s_tuser[0];
    item.is_hdr1 = (s_tdata == HDR1);
    item.is_hdr2 = (s_tdata == HDR2);
  end

endmodule
`default_nettype wire

### rtl/bdd_queue.sv
`default_nettype none
module bdd_queue
  import bdd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire bdd_item_t push_item,
  input  wire logic      pop,
  output bdd_item_t      head,
  output bdd_q_status_t  status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bdd_item_t     entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/bdd_back.sv
`default_nettype none
module bdd_back
  import bdd_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire bdd_item_t              head,
  input  wire bdd_q_status_t          q_status,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [31:0]                 m_tdata,  // payload_byte, block_number
  output logic [2:0]                  m_tuser   // kind
);

  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam logic [XFER_SIZE_W-1:0] BLK_XW = XFER_SIZE_W'(BLOCK_BYTES);
  localparam logic [BW-1:0]          BLK_BW = BW'(BLOCK_BYTES);

  logic [DEVICE_ID_W-1:0] device_id;
  logic [XFER_SIZE_W-1:0] transfer_size;

  phase_t                 phase, phase_next;
  logic [BW-1:0]          block_bytes_left, block_bytes_left_next;
  logic [XFER_SIZE_W-1:0] transfer_bytes_left, transfer_bytes_left_next;
  logic [15:0]            running_sum, running_sum_next;
  logic [7:0]             held_low_byte, held_low_byte_next;
  logic [BLOCK_NUM_W-1:0] block_count, block_count_next;
  logic                   failed, failed_next;

  // state as seen by this byte, after a restart has cleared it
  phase_t                 eff_phase;
  logic [BW-1:0]          eff_bbl;
  logic [XFER_SIZE_W-1:0] eff_tbl;
  logic [15:0]            eff_sum;
  logic [7:0]             eff_held;
  logic [BLOCK_NUM_W-1:0] eff_count;
  logic                   eff_failed;

  logic [15:0]            sum_add;
  logic [15:0]            word;
  logic [BW-1:0]          bbl_dec;
  logic [XFER_SIZE_W-1:0] tbl_dec;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [7:0]             res_byte;

  logic                   out_valid;
  kind_t                  out_kind;
  logic [7:0]             out_byte;
  logic [BLOCK_NUM_W-1:0] out_block;

  assign pop = q_status.valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id     <= DEVICE_ID_W'(1);
      transfer_size <= XFER_SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DEVICE_ID:     device_id     <= cfg_data[DEVICE_ID_W-1:0];
        REG_TRANSFER_SIZE: transfer_size <= cfg_data[XFER_SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    eff_phase  = head.restart ? PH_HDR1 : phase;
    eff_bbl    = head.restart ? '0 : block_bytes_left;
    eff_tbl    = head.restart ? transfer_size : transfer_bytes_left;
    eff_sum    = head.restart ? '0 : running_sum;
    eff_held   = head.restart ? '0 : held_low_byte;
    eff_count  = head.restart ? '0 : block_count;
    eff_failed = head.restart ? 1'b0 : failed;
    sum_add    = eff_sum + {8'h00, head.rx_byte};
    word       = {head.rx_byte, eff_held};
    bbl_dec    = (eff_bbl != '0) ? eff_bbl - BW'(1) : eff_bbl;
    tbl_dec    = (eff_tbl != '0) ? eff_tbl - XFER_SIZE_W'(1) : eff_tbl;
  end

  // next phase
  always_comb begin
    phase_next = eff_phase;
    if (!eff_failed) begin
      unique case (eff_phase)
        PH_HDR1: if (eff_tbl != '0 && head.is_hdr1) phase_next = PH_HDR2;
        PH_HDR2: if (head.is_hdr2) phase_next = PH_IDLO;
        PH_IDLO: phase_next = PH_IDHI;
        PH_IDHI: begin
          if (word == device_id) begin
            phase_next = (eff_bbl == '0) ? PH_CSLO : PH_DATA;
          end
        end
        PH_DATA: if (bbl_dec == '0) phase_next = PH_CSLO;
        PH_CSLO: phase_next = PH_CSHI;
        PH_CSHI: if (word == eff_sum) phase_next = PH_HDR1;
        default: phase_next = eff_phase;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    block_bytes_left_next    = eff_bbl;
    transfer_bytes_left_next = eff_tbl;
    running_sum_next         = eff_sum;
    held_low_byte_next       = eff_held;
    block_count_next         = eff_count;
    failed_next              = eff_failed;
    res_valid                = 1'b0;
    res_kind                 = KIND_PAYLOAD;
    res_byte                 = '0;
    if (!eff_failed) begin
      unique case (eff_phase)
        PH_HDR1: begin
          if (eff_tbl != '0) begin
            if (!head.is_hdr1) begin
              failed_next = 1'b1;
              res_valid   = 1'b1;
              res_kind    = KIND_BAD_HDR1;
            end else begin
              running_sum_next      = {8'h00, head.rx_byte};
              block_bytes_left_next = (eff_tbl > BLK_XW) ? BLK_BW : eff_tbl[BW-1:0];
            end
          end
        end
        PH_HDR2: begin
          if (!head.is_hdr2) begin
            failed_next = 1'b1;
            res_valid   = 1'b1;
            res_kind    = KIND_BAD_HDR2;
          end else begin
            running_sum_next = sum_add;
          end
        end
        PH_IDLO: begin
          held_low_byte_next = head.rx_byte;
          running_sum_next   = sum_add;
        end
        PH_IDHI: begin
          if (word != device_id) begin
            failed_next = 1'b1;
            res_valid   = 1'b1;
            res_kind    = KIND_BAD_ID;
          end else begin
            running_sum_next = sum_add;
          end
        end
        PH_DATA: begin
          running_sum_next         = sum_add;
          block_bytes_left_next    = bbl_dec;
          transfer_bytes_left_next = tbl_dec;
          res_valid                = 1'b1;
          res_kind                 = KIND_PAYLOAD;
          res_byte                 = head.rx_byte;
        end
        PH_CSLO: held_low_byte_next = head.rx_byte;
        PH_CSHI: begin
          res_valid = 1'b1;
          if (word != eff_sum) begin
            failed_next = 1'b1;
            res_kind    = KIND_BAD_CSUM;
          end else if (eff_tbl == '0) begin
            res_kind = KIND_DONE;
          end else begin
            res_kind         = KIND_GOOD;
            block_count_next = eff_count + BLOCK_NUM_W'(1);
          end
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HDR1;
      block_bytes_left    <= '0;
      transfer_bytes_left <= '0;
      running_sum         <= '0;
      held_low_byte       <= '0;
      block_count         <= '0;
      failed              <= 1'b0;
    end else if (pop) begin
      phase               <= phase_next;
      block_bytes_left    <= block_bytes_left_next;
      transfer_bytes_left <= transfer_bytes_left_next;
      running_sum         <= running_sum_next;
      held_low_byte       <= held_low_byte_next;
      block_count         <= block_count_next;
      failed              <= failed_next;
    end
  end

  // output register, refilled in the cycle it is taken when a byte is waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_kind  <= res_kind;
      out_byte  <= res_byte;
      out_block <= eff_count;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_block, out_byte};
  assign m_tuser  = out_kind;

`ifndef SYNTHESIS
  a_failed_sticky: assert property (@(posedge clk) disable iff (rst)
    (failed && !pop) |=> failed)
    else $error("failed flag dropped without a transfer");

  a_data_has_bytes: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (block_bytes_left != '0))
    else $error("payload phase with no bytes left in block");

  a_verdict_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != KIND_PAYLOAD) |-> (out_byte == 8'h00))
    else $error("verdict carries a nonzero payload byte");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !pop)
    else $error("queue popped while result still waiting");
`endif

endmodule
`default_nettype wire

### rtl/block_data_deframer_unit.sv
// Frame checker for a received byte stream. Each input transfer carries one byte in s_tdata
// and a restart flag in s_tuser; restart clears framing and loads transfer_size. Blocks are
// 0x5A, 0xA5, device ID (low byte first), up to BLOCK_BYTES payload bytes and a 16-bit sum
// checksum (low byte first). Payload bytes come out as they arrive (kind 0), each block ends
// with block good, transfer done, or the first error, after which bytes are dropped until a
// restart. The block takes one byte every cycle while the byte queue is not full; the framing
// state machine handles one byte per cycle while the output register is empty or being taken.
// A result passes through the four-entry byte queue and then the output register. Write device_id (index 0) and
// transfer_size (index 1) only while the stream is idle.
`default_nettype none
module block_data_deframer_unit
  import bdd_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // rx_byte
  input  wire logic [0:0]            s_tuser,   // restart
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [31:0]                m_tdata,   // payload_byte, block_number
  output logic [2:0]                 m_tuser    // kind
);

  bdd_q_status_t q_status;
  bdd_item_t     push_item;
  bdd_item_t     head;
  logic          push;
  logic          pop;

  bdd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_status (q_status),
    .push     (push),
    .item     (push_item)
  );

  bdd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  bdd_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire

### dv/deframer_checker.sv
`timescale 1ns / 100ps
module deframer_checker
  import bdd_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [7:0]            s_tdata,   // rx_byte
  input  wire logic [0:0]            s_tuser,   // restart
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [31:0]           m_tdata,   // payload_byte, block_number
  input  wire logic [2:0]            m_tuser,   // kind
  output int                         n_pending,
  output int                         n_errors
);

  typedef struct {
    kind_t                  kind;
    logic [7:0]             data;
    logic [BLOCK_NUM_W-1:0] blk;
  } deframe_event_t;

  deframe_event_t due_events[$];

  logic [DEVICE_ID_W-1:0] dev_id;
  logic [XFER_SIZE_W-1:0] xfer_size;

  phase_t                 ph;
  logic [15:0]            blk_left;
  logic [XFER_SIZE_W-1:0] xfer_left;
  logic [15:0]            csum;
  logic [7:0]             held;
  logic [BLOCK_NUM_W-1:0] blk_cnt;
  logic                   failed;

  initial begin
    n_pending = 0;
    n_errors  = 0;
  end

  task automatic note_event(kind_t k, logic [7:0] d);
    deframe_event_t ev;
    ev.kind = k;
    ev.data = d;
    ev.blk  = blk_cnt;
    due_events.push_back(ev);
  endtask

  // first error is reported once, then everything is dropped until a restart
  task automatic flag_error(kind_t k);
    failed = 1'b1;
    note_event(k, 8'h00);
  endtask

  task automatic advance_deframer(logic [7:0] b, logic rs);
    if (rs) begin
      ph        = PH_HDR1;
      blk_left  = '0;
      xfer_left = xfer_size;
      csum      = '0;
      held      = '0;
      blk_cnt   = '0;
      failed    = 1'b0;
    end
    if (!failed) begin
      case (ph)
        PH_HDR1: begin
          // nothing left in the transfer: idle, byte dropped
          if (xfer_left != 0) begin
            if (b != HDR1) begin
              flag_error(KIND_BAD_HDR1);
            end else begin
              csum     = {8'h00, b};
              blk_left = (xfer_left > BLOCK_BYTES) ? 16'(BLOCK_BYTES) : xfer_left[15:0];
              ph       = PH_HDR2;
            end
          end
        end
        PH_HDR2: begin
          if (b != HDR2) begin
            flag_error(KIND_BAD_HDR2);
          end else begin
            csum = csum + b;
            ph   = PH_IDLO;
          end
        end
        PH_IDLO: begin
          held = b;
          csum = csum + b;
          ph   = PH_IDHI;
        end
        PH_IDHI: begin
          if ({b, held} != dev_id) begin
            flag_error(KIND_BAD_ID);
          end else begin
            csum = csum + b;
            ph   = (blk_left == 0) ? PH_CSLO : PH_DATA;
          end
        end
        PH_DATA: begin
          csum = csum + b;
          if (blk_left != 0) blk_left = blk_left - 1'b1;
          if (xfer_left != 0) xfer_left = xfer_left - 1'b1;
          if (blk_left == 0) ph = PH_CSLO;
          note_event(KIND_PAYLOAD, b);
        end
        PH_CSLO: begin
          held = b;
          ph   = PH_CSHI;
        end
        PH_CSHI: begin
          if ({b, held} != csum) begin
            flag_error(KIND_BAD_CSUM);
          end else begin
            ph = PH_HDR1;
            if (xfer_left == 0) begin
              note_event(KIND_DONE, 8'h00);
            end else begin
              note_event(KIND_GOOD, 8'h00);
              blk_cnt = blk_cnt + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    deframe_event_t ev;
    if (rst) begin
      dev_id    = 16'd1;
      xfer_size = 24'd1;
      ph        = PH_HDR1;
      blk_left  = '0;
      xfer_left = '0;
      csum      = '0;
      held      = '0;
      blk_cnt   = '0;
      failed    = 1'b0;
      due_events.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_events.size() == 0) begin
          n_errors++;
          $display("%0t: result with none due: expected none, got kind %0d data %0d block %0d",
                   $time, m_tuser, m_tdata[7:0], m_tdata[31:8]);
        end else begin
          ev = due_events.pop_front();
          if (m_tuser !== ev.kind) begin
            n_errors++;
            $display("%0t: kind expected %0d got %0d", $time, ev.kind, m_tuser);
          end
          if (m_tdata[7:0] !== ev.data) begin
            n_errors++;
            $display("%0t: payload_byte expected %0d got %0d", $time, ev.data, m_tdata[7:0]);
          end
          if (m_tdata[31:8] !== ev.blk) begin
            n_errors++;
            $display("%0t: block_number expected %0d got %0d", $time, ev.blk, m_tdata[31:8]);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ID:     dev_id = cfg_data[DEVICE_ID_W-1:0];
          REG_TRANSFER_SIZE: xfer_size = cfg_data[XFER_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) advance_deframer(s_tdata, s_tuser[0]);
    end
    n_pending = due_events.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import bdd_pkg::*;

  localparam int BLOCK_BYTES    = BLOCK_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int STALL_CYCLES   = 300;
  localparam int SETTLE_CYCLES  = 6;

  typedef enum {ERR_NONE, ERR_HDR1, ERR_HDR2, ERR_ID, ERR_CSUM} frame_err_t;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
  } link_byte_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [0:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic [2:0]            m_tuser;

  int n_pending;
  int n_errors;

  link_byte_t byte_stream[$];
  int         n_queued = 0;
  int         n_accepted = 0;
  int         quiet_cycles = 0;
  bit         tx_idling = 1'b0;
  bit         rx_idling = 1'b0;
  bit         stall_req = 1'b0;

  // what the stimulus believes the block is configured with
  logic [DEVICE_ID_W-1:0] id_now = 16'd1;
  logic [XFER_SIZE_W-1:0] size_now = 24'd1;

  block_data_deframer_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  deframer_checker #(.BLOCK_BYTES(BLOCK_BYTES)) u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .n_pending(n_pending), .n_errors(n_errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : sender
    int gap;
    link_byte_t nxt;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (s_tvalid && s_tready) n_accepted++;
        if (!s_tvalid || s_tready) begin
          if (gap > 0) begin
            gap--;
            s_tvalid <= 1'b0;
          end else if (byte_stream.size() == 0) begin
            s_tvalid <= 1'b0;
          end else if (tx_idling && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 19) - 1;
            s_tvalid <= 1'b0;
          end else begin
            nxt = byte_stream.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= nxt.data;
            s_tuser  <= nxt.restart;
          end
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold = STALL_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] bad_byte(logic [7:0] good);
    return good ^ 8'($urandom_range(1, 255));
  endfunction

  task automatic push_byte(logic [7:0] b, bit rs);
    link_byte_t it;
    it.data    = b;
    it.restart = rs;
    byte_stream.push_back(it);
    n_queued++;
  endtask

  // one block frame; keep < 0 sends it whole, else only its first keep bytes
  task automatic push_frame(int n, bit rs, frame_err_t err, int keep);
    logic [7:0]  fb[$];
    logic [15:0] sum;
    logic [7:0]  b;
    fb.push_back(err == ERR_HDR1 ? bad_byte(HDR1) : HDR1);
    fb.push_back(err == ERR_HDR2 ? bad_byte(HDR2) : HDR2);
    fb.push_back(id_now[7:0]);
    fb.push_back(err == ERR_ID ? bad_byte(id_now[15:8]) : id_now[15:8]);
    sum = '0;
    foreach (fb[i]) sum = sum + fb[i];
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      fb.push_back(b);
      sum = sum + b;
    end
    if (err == ERR_CSUM) sum = sum ^ 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(sum[7:0]);
    fb.push_back(sum[15:8]);
    if (keep < 0 || keep > fb.size()) keep = fb.size();
    for (int i = 0; i < keep; i++) push_byte(fb[i], rs && i == 0);
  endtask

  task automatic push_transfer(frame_err_t err, int keep);
    int  left;
    int  n;
    bit  first;
    left  = size_now;
    first = 1'b1;
    // zero transfer size: the restart byte just leaves the block idle
    if (left == 0) push_byte(HDR1, 1'b1);
    while (left > 0) begin
      n = (left > BLOCK_BYTES) ? BLOCK_BYTES : left;
      push_frame(n, first, err, keep);
      if (err != ERR_NONE || keep >= 0) break;
      left  = left - n;
      first = 1'b0;
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_link(logic [DEVICE_ID_W-1:0] id, logic [XFER_SIZE_W-1:0] size);
    write_reg(REG_DEVICE_ID, CFG_DATA_W'(id));
    write_reg(REG_TRANSFER_SIZE, size);
    id_now   = id;
    size_now = size;
  endtask

  // wait until every byte went in and every result came out, then let it settle
  task automatic drain();
    do @(negedge clk); while (n_accepted != n_queued || n_pending != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int pick;
    logic [DEVICE_ID_W-1:0] id_pick;
    logic [XFER_SIZE_W-1:0] size_pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bytes before any restart are dropped
    push_byte(HDR1, 1'b0);
    push_byte(8'hFF, 1'b0);
    // reset settings: one-byte transfer, then a byte after it finished
    push_frame(1, 1'b1, ERR_NONE, -1);
    push_byte(HDR1, 1'b0);
    push_frame(1, 1'b1, ERR_HDR1, 1);
    push_byte(HDR1, 1'b0);
    push_frame(1, 1'b1, ERR_HDR2, 2);
    drain();

    set_link(16'hFFFF, 24'd0);
    push_byte(HDR1, 1'b1);
    push_byte(HDR2, 1'b0);
    drain();

    set_link(16'hFFFF, 24'd2);
    push_frame(2, 1'b1, ERR_ID, 4);
    push_frame(2, 1'b1, ERR_CSUM, -1);
    drain();

    tx_idling = 1'b1;
    rx_idling = 1'b1;

    // largest transfer size: one full block, then part of the next, under a long stall
    set_link(16'($urandom), 24'hFFFFFF);
    stall_req = 1'b1;
    push_frame(BLOCK_BYTES, 1'b1, ERR_NONE, -1);
    push_frame(BLOCK_BYTES, 1'b0, ERR_NONE, 9);
    drain();

    for (int p = 0; p < 10; p++) begin
      if (p == 8) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      pick = $urandom_range(0, 3);
      id_pick = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      pick = $urandom_range(0, 9);
      size_pick = (pick == 0) ? 24'd0 : (pick == 1) ? 24'd1 : 24'($urandom_range(2, 24));
      set_link(id_pick, size_pick);
      repeat ($urandom_range(2, 4)) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          push_transfer(ERR_NONE, -1);
        end else if (pick < 16) begin
          push_transfer(frame_err_t'(pick - 11), -1);
        end else if (pick < 18) begin
          // cut off mid-frame, the next restart picks up
          push_transfer(ERR_NONE, $urandom_range(1, size_now + 5));
        end else begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
        end
      end
      drain();
    end

    if (n_errors == 0 && n_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (n_pending != 0) $display("%0t: %0d results still due", $time, n_pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
